@@ hw/rtl/hvt_pkg.sv @@
package hvt_pkg;

    localparam int HVT_FRAC_BITS = 16;
    localparam int HVT_NUM_REGS  = 8;
    localparam int HVT_ADDR_W    = 6;
    localparam int HVT_DATA_W    = 64;
    localparam int HVT_COMP_W    = 32;
    localparam int HVT_PROD_W    = 2 * HVT_COMP_W;
    localparam int HVT_SUM_W     = HVT_PROD_W + 2;
    // Quotient bits kept by the divider: 32 result bits plus one for the
    // most negative value.
    localparam int HVT_QUO_W     = HVT_COMP_W + 1;

    localparam logic [HVT_COMP_W-1:0] HVT_COMP_MAX = 32'h7fff_ffff;
    localparam logic [HVT_COMP_W-1:0] HVT_COMP_MIN = 32'h8000_0000;

    typedef logic signed [HVT_COMP_W-1:0] hvt_comp_t;

    typedef struct packed {
        logic vld;
        logic point;
    } hvt_ctl_t;

endpackage

@@ hw/rtl/vtx_if.sv @@
interface vtx_in_if
    import hvt_pkg::*;
();
    logic      valid;
    logic      ready;
    logic      req_type;
    hvt_comp_t in_x;
    hvt_comp_t in_y;
    hvt_comp_t in_z;
    hvt_comp_t in_w;

    modport source (output valid, req_type, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, req_type, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtx_out_if
    import hvt_pkg::*;
();
    logic      valid;
    logic      ready;
    hvt_comp_t out_x;
    hvt_comp_t out_y;
    hvt_comp_t out_z;
    hvt_comp_t out_w;
    logic      overflow;
    logic      divide_by_zero;

    modport source (output valid, out_x, out_y, out_z, out_w, overflow, divide_by_zero,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, divide_by_zero,
                    output ready);
endinterface

@@ hw/rtl/hvt_regs.sv @@
module hvt_regs
    import hvt_pkg::*;
#(
    parameter int FRAC_BITS = HVT_FRAC_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [HVT_ADDR_W-1:0]                   paddr,
    input  logic [HVT_DATA_W-1:0]                   pwdata,
    output logic [HVT_DATA_W-1:0]                   prdata,
    output logic                                    pready,
    output logic [HVT_NUM_REGS-1:0][HVT_DATA_W-1:0] mat
);

    localparam logic [HVT_DATA_W-1:0] ONE_LO = HVT_DATA_W'(1) << FRAC_BITS;
    localparam logic [HVT_DATA_W-1:0] ONE_HI = ONE_LO << HVT_COMP_W;

    logic [HVT_NUM_REGS-1:0][HVT_DATA_W-1:0] mat_reg;
    logic [2:0]                              idx;

    assign idx    = paddr[HVT_ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = mat_reg[idx];
    assign mat    = mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg    <= '0;
            mat_reg[0] <= ONE_LO;
            mat_reg[2] <= ONE_HI;
            mat_reg[5] <= ONE_LO;
            mat_reg[7] <= ONE_HI;
        end
        else if (psel && penable && pwrite)
        begin
            mat_reg[idx] <= pwdata;
        end
    end

endmodule

@@ hw/rtl/hvt_dot.sv @@
module hvt_dot
    import hvt_pkg::*;
#(
    parameter int FRAC_BITS = HVT_FRAC_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  hvt_ctl_t                                ctl_i,
    input  hvt_comp_t                               vx,
    input  hvt_comp_t                               vy,
    input  hvt_comp_t                               vz,
    input  hvt_comp_t                               vw,
    input  logic [HVT_NUM_REGS-1:0][HVT_DATA_W-1:0] mat,
    output hvt_ctl_t                                ctl_o,
    output logic signed [HVT_SUM_W-FRAC_BITS-1:0]   dot_o [0:3]
);

    localparam int DW = HVT_SUM_W - FRAC_BITS;
    localparam logic [HVT_COMP_W-1:0] ONE = HVT_COMP_W'(1) << FRAC_BITS;

    hvt_comp_t                    v [0:3];
    logic signed [HVT_PROD_W-1:0] prod_reg [0:3][0:3];
    hvt_ctl_t                     ctl1_reg;
    hvt_ctl_t                     ctl2_reg;
    logic signed [DW-1:0]         dot_reg [0:3];

    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;
    // A point always has w equal to one.
    assign v[3] = ctl_i.point ? hvt_comp_t'(ONE) : vw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_i;
            ctl2_reg <= ctl1_reg;
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        logic signed [HVT_SUM_W-1:0] sum;

        for (genvar c = 0; c < 4; c++)
        begin : g_col
            hvt_comp_t coef;

            assign coef = hvt_comp_t'(mat[r*2 + c/2][(c%2)*HVT_COMP_W +: HVT_COMP_W]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[r][c] <= coef * v[c];
                end
            end
        end

        assign sum = HVT_SUM_W'(prod_reg[r][0]) + HVT_SUM_W'(prod_reg[r][1])
                   + HVT_SUM_W'(prod_reg[r][2]) + HVT_SUM_W'(prod_reg[r][3]);

        // The arithmetic right shift rounds toward minus infinity.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dot_reg[r] <= sum[HVT_SUM_W-1:FRAC_BITS];
            end
        end

        assign dot_o[r] = dot_reg[r];
    end

    assign ctl_o = ctl2_reg;

endmodule

@@ hw/rtl/hvt_div.sv @@
module hvt_div
    import hvt_pkg::*;
#(
    parameter int FRAC_BITS = HVT_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  hvt_ctl_t                              ctl_i,
    input  logic signed [HVT_SUM_W-FRAC_BITS-1:0] dot_i [0:3],
    output logic                                  out_vld,
    output hvt_comp_t                             out_x,
    output hvt_comp_t                             out_y,
    output hvt_comp_t                             out_z,
    output hvt_comp_t                             out_w,
    output logic                                  out_ov,
    output logic                                  out_dz
);

    localparam int MW = HVT_SUM_W - FRAC_BITS;
    localparam int QB = HVT_QUO_W;
    localparam logic [HVT_COMP_W-1:0] ONE = HVT_COMP_W'(1) << FRAC_BITS;
    localparam logic [QB-1:0] NEG_LIM = QB'(1) << (HVT_COMP_W - 1);
    localparam logic [QB-1:0] POS_LIM = QB'(HVT_COMP_MAX);

    // Stage A: saturation for full products, magnitudes for the divide.
    hvt_ctl_t              a_ctl_reg;
    logic [HVT_COMP_W-1:0] a_sat_reg [0:3];
    logic                  a_ov_reg;
    logic [MW-1:0]         a_mag_reg [0:2];
    logic [2:0]            a_neg_reg;
    logic [MW-1:0]         a_b_reg;
    logic                  a_dz_reg;

    logic [HVT_COMP_W-1:0] sat [0:3];
    logic [3:0]            sat_ov;
    logic [MW-1:0]         b_mag;

    for (genvar r = 0; r < 4; r++)
    begin : g_sat
        logic [MW-HVT_COMP_W:0] hi;

        assign hi = dot_i[r][MW-1:HVT_COMP_W-1];
        assign sat_ov[r] = !((&hi) || !(|hi));
        assign sat[r] = !sat_ov[r] ? dot_i[r][HVT_COMP_W-1:0]
                      : (dot_i[r][MW-1] ? HVT_COMP_MIN : HVT_COMP_MAX);
    end

    assign b_mag = dot_i[3][MW-1] ? (~dot_i[3] + MW'(1)) : dot_i[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
        end
        else if (en)
        begin
            a_ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a_sat_reg[r] <= sat[r];
            end
            for (int l = 0; l < 3; l++)
            begin
                a_mag_reg[l] <= dot_i[l][MW-1] ? (~dot_i[l] + MW'(1)) : dot_i[l];
                a_neg_reg[l] <= dot_i[l][MW-1] ^ dot_i[3][MW-1];
            end
            a_ov_reg <= |sat_ov;
            a_b_reg  <= b_mag;
            a_dz_reg <= (dot_i[3] == '0);
        end
    end

    // Divider chain: index 0 holds the prepared dividend, each later index
    // has retired one more quotient bit.
    hvt_ctl_t              ctl_reg  [0:QB];
    logic [HVT_COMP_W-1:0] sat_reg  [0:QB][0:3];
    logic                  ov_reg   [0:QB];
    logic                  dz_reg   [0:QB];
    logic [MW-1:0]         b_reg    [0:QB];
    logic [MW-1:0]         rem_reg  [0:QB][0:2];
    logic [QB-1:0]         abit_reg [0:QB][0:2];
    logic [QB-1:0]         q_reg    [0:QB][0:2];
    logic [2:0]            neg_reg  [0:QB];
    logic [2:0]            hov_reg  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= a_ctl_reg;
            for (int k = 1; k <= QB; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_prep
        logic [HVT_SUM_W-1:0] dvd;
        logic [MW-1:0]        top;
        logic                 hov;

        assign dvd = {a_mag_reg[l], FRAC_BITS'(0)};
        assign top = MW'(dvd[HVT_SUM_W-1:QB]);
        // A quotient too large for the kept bits saturates outright.
        assign hov = (top >= a_b_reg);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0][l]  <= hov ? '0 : top;
                abit_reg[0][l] <= dvd[QB-1:0];
                q_reg[0][l]    <= '0;
                hov_reg[0][l]  <= hov;
                neg_reg[0][l]  <= a_neg_reg[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= a_sat_reg;
            ov_reg[0]  <= a_ov_reg;
            dz_reg[0]  <= a_dz_reg;
            b_reg[0]   <= a_b_reg;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [MW:0] rs;
            logic [MW:0] diff;
            logic        ge;

            assign rs   = {rem_reg[k-1][l], abit_reg[k-1][l][QB-1]};
            assign diff = rs - {1'b0, b_reg[k-1]};
            assign ge   = (rs >= {1'b0, b_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][l]  <= ge ? diff[MW-1:0] : rs[MW-1:0];
                    abit_reg[k][l] <= {abit_reg[k-1][l][QB-2:0], 1'b0};
                    q_reg[k][l]    <= {q_reg[k-1][l][QB-2:0], ge};
                    hov_reg[k][l]  <= hov_reg[k-1][l];
                    neg_reg[k][l]  <= neg_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[k] <= sat_reg[k-1];
                ov_reg[k]  <= ov_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
                b_reg[k]   <= b_reg[k-1];
            end
        end
    end

    // Sign and saturate the quotients, then pick the result by mode.
    logic [HVT_COMP_W-1:0] quo [0:2];
    logic [2:0]            quo_ov;

    for (genvar l = 0; l < 3; l++)
    begin : g_fin
        logic [QB-1:0] q;
        logic [QB-1:0] qn;

        assign q  = q_reg[QB][l];
        assign qn = ~q + QB'(1);

        always_comb
        begin
            quo[l]    = q[HVT_COMP_W-1:0];
            quo_ov[l] = 1'b0;
            if (hov_reg[QB][l])
            begin
                quo[l]    = neg_reg[QB][l] ? HVT_COMP_MIN : HVT_COMP_MAX;
                quo_ov[l] = 1'b1;
            end
            else if (neg_reg[QB][l])
            begin
                quo_ov[l] = (q > NEG_LIM);
                quo[l]    = quo_ov[l] ? HVT_COMP_MIN : qn[HVT_COMP_W-1:0];
            end
            else
            begin
                quo_ov[l] = (q > POS_LIM);
                quo[l]    = quo_ov[l] ? HVT_COMP_MAX : q[HVT_COMP_W-1:0];
            end
        end
    end

    logic                  vld_reg;
    logic [HVT_COMP_W-1:0] x_reg, y_reg, z_reg, w_reg;
    logic                  ovf_reg, dz_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= ctl_reg[QB].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!ctl_reg[QB].point)
            begin
                x_reg      <= sat_reg[QB][0];
                y_reg      <= sat_reg[QB][1];
                z_reg      <= sat_reg[QB][2];
                w_reg      <= sat_reg[QB][3];
                ovf_reg    <= ov_reg[QB];
                dz_out_reg <= 1'b0;
            end
            else if (dz_reg[QB])
            begin
                x_reg      <= '0;
                y_reg      <= '0;
                z_reg      <= '0;
                w_reg      <= ONE;
                ovf_reg    <= 1'b0;
                dz_out_reg <= 1'b1;
            end
            else
            begin
                x_reg      <= quo[0];
                y_reg      <= quo[1];
                z_reg      <= quo[2];
                w_reg      <= ONE;
                ovf_reg    <= |quo_ov;
                dz_out_reg <= 1'b0;
            end
        end
    end

    assign out_vld = vld_reg;
    assign out_x   = hvt_comp_t'(x_reg);
    assign out_y   = hvt_comp_t'(y_reg);
    assign out_z   = hvt_comp_t'(z_reg);
    assign out_w   = hvt_comp_t'(w_reg);
    assign out_ov  = ovf_reg;
    assign out_dz  = dz_out_reg;

endmodule

@@ hw/rtl/homogeneous_vertex_transform.sv @@
// Transforms one vector per word by a 4x4 matrix of signed fixed-point
// coefficients set through the APB registers (identity after reset). Mode 0
// returns the full product; mode 1 treats the input as a point with w = 1,
// divides x, y and z by the row-3 result and returns w = 1.0. A new word is
// taken every cycle while the output is not stalled and passes in turn through
// products, row sums, sign handling, divisor check, one quotient bit per stage
// for 33 stages and the output register. The whole pipeline holds while the
// output word waits, so nothing is lost or repeated; registers should be
// written only while the pipeline is empty.
module homogeneous_vertex_transform
    import hvt_pkg::*;
#(
    parameter int FRAC_BITS = HVT_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [HVT_ADDR_W-1:0] paddr,
    input  logic [HVT_DATA_W-1:0] pwdata,
    output logic [HVT_DATA_W-1:0] prdata,
    output logic                  pready,
    vtx_in_if.sink                in_ch,
    vtx_out_if.source             out_ch
);

    localparam int DW = HVT_SUM_W - FRAC_BITS;
    localparam logic [HVT_COMP_W-1:0] ONE = HVT_COMP_W'(1) << FRAC_BITS;

    logic                                    en;
    logic [HVT_NUM_REGS-1:0][HVT_DATA_W-1:0] mat;
    hvt_ctl_t                                in_ctl;
    hvt_ctl_t                                dot_ctl;
    logic signed [DW-1:0]                    dot [0:3];

    assign en           = !out_ch.valid || out_ch.ready;
    assign in_ch.ready  = en;
    assign in_ctl.vld   = in_ch.valid;
    assign in_ctl.point = in_ch.req_type;

    hvt_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    hvt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl_i (in_ctl),
        .vx    (in_ch.in_x),
        .vy    (in_ch.in_y),
        .vz    (in_ch.in_z),
        .vw    (in_ch.in_w),
        .mat   (mat),
        .ctl_o (dot_ctl),
        .dot_o (dot)
    );

    hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_i   (dot_ctl),
        .dot_i   (dot),
        .out_vld (out_ch.valid),
        .out_x   (out_ch.out_x),
        .out_y   (out_ch.out_y),
        .out_z   (out_ch.out_z),
        .out_w   (out_ch.out_w),
        .out_ov  (out_ch.overflow),
        .out_dz  (out_ch.divide_by_zero)
    );

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.divide_by_zero |->
            out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0
            && !out_ch.overflow)
        else $error("zero divisor result is not cleared");

    a_dz_w: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.divide_by_zero |-> out_ch.out_w == hvt_comp_t'(ONE))
        else $error("zero divisor result has wrong w");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |=> $stable(dot_ctl) && $stable(out_ch.valid))
        else $error("pipeline moved during a stall");

endmodule
